// File: hdl/bslp_pkg.sv
// Shared types, codes and field widths for the box label painter.
package bslp_pkg;

	// Table depth default
	localparam int unsigned BSLP_MAX_DET = 32;

	// Field widths
	localparam int unsigned BOX_POS_W  = 13;
	localparam int unsigned BOX_SIZE_W = 12;
	localparam int unsigned CLASS_W    = 10;
	localparam int unsigned CONF_W     = 16;
	localparam int unsigned PIX_W      = 12;
	localparam int unsigned IMG_DIM_W  = 13;
	localparam int unsigned PCLASS_W   = 11;
	localparam int unsigned CODE_W     = 2;
	localparam int unsigned S_TDATA_W  = 104;
	localparam int unsigned M_TDATA_W  = 32;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// Command codes (s_tuser)
	localparam logic [CODE_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CODE_W-1:0] CMD_ADD   = 2'd1;
	localparam logic [CODE_W-1:0] CMD_QUERY = 2'd2;

	// Result status codes (m_tuser)
	localparam logic [CODE_W-1:0] STAT_OK       = 2'd0;
	localparam logic [CODE_W-1:0] STAT_LOW_CONF = 2'd1;
	localparam logic [CODE_W-1:0] STAT_FULL     = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_CONF = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMG_W    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IMG_H    = 2'd2;

	// Configuration reset values
	localparam logic [IMG_DIM_W-1:0] IMG_W_RST = 13'd640;
	localparam logic [IMG_DIM_W-1:0] IMG_H_RST = 13'd480;

	// One stored detection
	typedef struct packed {
		logic signed [BOX_POS_W-1:0] x;
		logic signed [BOX_POS_W-1:0] y;
		logic [BOX_SIZE_W-1:0]       w;
		logic [BOX_SIZE_W-1:0]       h;
		logic [CLASS_W-1:0]          cls;
		logic [CONF_W-1:0]           conf;
	} bslp_entry_t;

	// Controller state
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FLUSH,
		S_PUT
	} bslp_state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic scan_rd;
		logic put;
	} bslp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic go_scan;
		logic scan_last;
		logic out_free;
	} bslp_sts_t;

endpackage

// File: hdl/bslp_dp.sv
// Datapath: detection table, configuration registers, query scan and result register.
module bslp_dp #(
	parameter int unsigned MAX_DETECTIONS = bslp_pkg::BSLP_MAX_DET
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bslp_pkg::bslp_cmd_t              cmd,
	output bslp_pkg::bslp_sts_t              sts,
	input  logic [bslp_pkg::CODE_W-1:0]      s_tuser,
	input  logic [bslp_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [bslp_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic [bslp_pkg::CODE_W-1:0]      m_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bslp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bslp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bslp_pkg::*;

	localparam int unsigned IDX_W = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_DETECTIONS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DETECTIONS);

	// Input fields
	logic signed [BOX_POS_W-1:0] in_x, in_y;
	logic [BOX_SIZE_W-1:0]       in_w, in_h;
	logic [CLASS_W-1:0]          in_cls;
	logic [CONF_W-1:0]           in_conf;
	logic [PIX_W-1:0]            in_px, in_py;

	assign in_x    = s_tdata[12:0];
	assign in_y    = s_tdata[25:13];
	assign in_w    = s_tdata[37:26];
	assign in_h    = s_tdata[49:38];
	assign in_cls  = s_tdata[59:50];
	assign in_conf = s_tdata[75:60];
	assign in_px   = s_tdata[87:76];
	assign in_py   = s_tdata[99:88];

	// Configuration registers
	logic [CONF_W-1:0]    min_conf_q;
	logic [IMG_DIM_W-1:0] img_w_q, img_h_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_conf_q <= '0;
			img_w_q    <= IMG_W_RST;
			img_h_q    <= IMG_H_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MIN_CONF: min_conf_q <= cfg_data;
				CFG_IMG_W:    img_w_q    <= cfg_data[IMG_DIM_W-1:0];
				CFG_IMG_H:    img_h_q    <= cfg_data[IMG_DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Add checks: confidence first, then space
	logic [CNT_W-1:0] count_q;
	logic             is_add, low_conf, full, add_ok, is_cmd;

	assign is_cmd   = cmd.accept;
	assign is_add   = (s_tuser == CMD_ADD);
	assign low_conf = (in_conf < min_conf_q);
	assign full     = (count_q == CNT_MAX);
	assign add_ok   = is_cmd && is_add && !low_conf && !full;

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (is_cmd && s_tuser == CMD_CLEAR) begin
			count_q <= '0;
		end else if (add_ok) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// Detection table, one write port, one registered read port
	bslp_entry_t      mem [MAX_DETECTIONS];
	bslp_entry_t      rd_s1;
	logic [IDX_W-1:0] scan_idx_q;

	always_ff @(posedge clk) begin
		if (add_ok) begin
			mem[count_q[IDX_W-1:0]] <= '{x: in_x, y: in_y, w: in_w, h: in_h,
			                             cls: in_cls, conf: in_conf};
		end
		if (cmd.scan_rd) begin
			rd_s1 <= mem[scan_idx_q];
		end
	end

	// Scan address and read-valid flag
	logic rd_vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
			if (is_cmd) begin
				scan_idx_q <= '0;
			end else if (cmd.scan_rd) begin
				scan_idx_q <= scan_idx_q + IDX_W'(1);
			end
		end
	end

	// Query needs a scan only when the pixel is inside and the table holds entries
	assign sts.go_scan   = (s_tuser == CMD_QUERY)
	                    && ({1'b0, in_px} < img_w_q)
	                    && ({1'b0, in_py} < img_h_q)
	                    && (count_q != '0);
	assign sts.scan_last = ((CNT_W'(scan_idx_q) + CNT_W'(1)) == count_q);
	assign sts.out_free  = !m_tvalid || m_tready;

	// Coverage and strictly-greater test on the entry read last cycle
	logic [PIX_W-1:0]    px_q, py_q;
	logic [CODE_W-1:0]   status_q;
	logic [PCLASS_W-1:0] best_cls_q;
	logic [CONF_W-1:0]   best_conf_q;
	logic signed [13:0]  px_e, py_e, x_lo, y_lo, x_hi, y_hi;
	logic                hit;

	assign px_e = signed'({2'b00, px_q});
	assign py_e = signed'({2'b00, py_q});
	assign x_lo = {rd_s1.x[BOX_POS_W-1], rd_s1.x};
	assign y_lo = {rd_s1.y[BOX_POS_W-1], rd_s1.y};
	assign x_hi = x_lo + signed'({2'b00, rd_s1.w});
	assign y_hi = y_lo + signed'({2'b00, rd_s1.h});
	// An empty box fails the upper bound on its own
	assign hit  = (px_e >= x_lo) && (px_e < x_hi) && (py_e >= y_lo) && (py_e < y_hi)
	           && (rd_s1.conf > best_conf_q);

	// Per-transaction working registers
	always_ff @(posedge clk) begin
		if (is_cmd) begin
			px_q        <= in_px;
			py_q        <= in_py;
			best_cls_q  <= '1;
			best_conf_q <= '0;
			if (!is_add) begin
				status_q <= STAT_OK;
			end else if (low_conf) begin
				status_q <= STAT_LOW_CONF;
			end else if (full) begin
				status_q <= STAT_FULL;
			end else begin
				status_q <= STAT_OK;
			end
		end else if (rd_vld_s1 && hit) begin
			best_cls_q  <= {1'b0, rd_s1.cls};
			best_conf_q <= rd_s1.conf;
		end
	end

	// Result register
	logic [CODE_W-1:0]   out_status_q;
	logic [PCLASS_W-1:0] out_cls_q;
	logic [CONF_W-1:0]   out_conf_q;
	logic                out_vld_q;

	always_ff @(posedge clk) begin
		if (cmd.put) begin
			out_status_q <= status_q;
			out_cls_q    <= best_cls_q;
			out_conf_q   <= best_conf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.put) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{(M_TDATA_W - CONF_W - PCLASS_W){1'b0}}, out_conf_q, out_cls_q};

	// Table never grows past its depth
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("entry count beyond table depth");

	// Dropped adds carry the empty answer
	a_drop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != STAT_OK) |-> (out_cls_q == '1 && out_conf_q == '0))
		else $error("dropped add with a class or confidence");

	// Scan reads only filled entries
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_rd |-> (CNT_W'(scan_idx_q) < count_q))
		else $error("scan read beyond entry count");

endmodule

// File: hdl/bslp_ctrl.sv
// Controller: sequences accept, table scan, compare flush and result hand-off.
module bslp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  bslp_pkg::bslp_sts_t sts,
	output bslp_pkg::bslp_cmd_t cmd
);
	import bslp_pkg::*;

	bslp_state_t state_q, state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
				if (s_tvalid) begin
					state_nxt = sts.go_scan ? S_SCAN : S_PUT;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_nxt = S_FLUSH;
				end
			end
			// last read entry is compared here
			S_FLUSH: begin
				state_nxt = S_PUT;
			end
			S_PUT: begin
				if (sts.out_free) begin
					cmd.put   = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// One transaction at a time
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !s_tready)
		else $error("input taken while a transaction is in flight");

	// Result register never overwritten while full
	a_put_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |-> sts.out_free)
		else $error("result loaded over an untaken result");

	// Back to accepting right after the hand-off
	a_put_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |=> s_tready)
		else $error("not ready after result hand-off");

endmodule

// File: hdl/box_semantic_label_painter_core.sv
// Top level of the box label painter: controller plus datapath.
// Holds up to MAX_DETECTIONS boxes with class and confidence. Clear and add pass through
// accept and result load, then output; a query passes through accept, a scan of the
// stored entries, a compare flush and result load, because the table memory
// is read through its single registered port one entry per cycle and each entry is
// compared in the cycle after its read. A query on a pixel outside the image or on an
// empty table skips the scan. The result waits in an output register; a new input
// transaction is taken once the previous result is loaded there. Configuration writes
// are always taken (cfg_ready is tied high) and must only be issued while idle.
module box_semantic_label_painter_core #(
	parameter int unsigned MAX_DETECTIONS = bslp_pkg::BSLP_MAX_DET
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// box_x[12:0] box_y[25:13] box_width[37:26] box_height[49:38] det_class[59:50]
	// det_confidence[75:60] pixel_x[87:76] pixel_y[99:88], zero pad [103:100]
	input  logic [bslp_pkg::S_TDATA_W-1:0]   s_tdata,
	// command[1:0]
	input  logic [bslp_pkg::CODE_W-1:0]      s_tuser,
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// pixel_class[10:0] pixel_confidence[26:11], zero pad [31:27]
	output logic [bslp_pkg::M_TDATA_W-1:0]   m_tdata,
	// status[1:0]
	output logic [bslp_pkg::CODE_W-1:0]      m_tuser,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bslp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bslp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bslp_pkg::*;

	bslp_cmd_t cmd;
	bslp_sts_t sts;

	bslp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bslp_dp #(
		.MAX_DETECTIONS (MAX_DETECTIONS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

// File: tb/tb.sv
// Self-checking testbench for the box label painter core.
`timescale 1ns / 1ps

module tb;
	import bslp_pkg::*;

	localparam logic [CODE_W-1:0]   CMD_NOP      = 2'd3;	// unused code, must act as no-op
	localparam logic [PCLASS_W-1:0] NO_CLASS     = 11'h7FF;
	localparam int                  CYCLE_LIMIT  = 400000;
	localparam int                  LONG_HOLD    = 300;
	localparam int                  LONG_HOLD_AT = 120;

	typedef struct {
		logic [CODE_W-1:0]    status;
		logic [PCLASS_W-1:0]  cls;
		logic [CONF_W-1:0]    conf;
	} answer_t;

	typedef struct {
		logic [CODE_W-1:0]     cmd;
		logic [BOX_POS_W-1:0]  bx;
		logic [BOX_POS_W-1:0]  by;
		logic [BOX_SIZE_W-1:0] bw;
		logic [BOX_SIZE_W-1:0] bh;
		logic [CLASS_W-1:0]    cls;
		logic [CONF_W-1:0]     conf;
		logic [PIX_W-1:0]      px;
		logic [PIX_W-1:0]      py;
	} det_item_t;

	typedef struct {
		int x;
		int y;
		int w;
		int h;
	} rect_t;

	// Scoreboard: shadow detection table plus queue of awaited answers
	class label_oracle;
		bslp_entry_t          slot [BSLP_MAX_DET];
		int                   fill;
		logic [CONF_W-1:0]    min_conf;
		logic [IMG_DIM_W-1:0] img_w;
		logic [IMG_DIM_W-1:0] img_h;
		answer_t              awaited [$];
		int                   errors;

		function new();
			fill = 0;
			min_conf = '0;
			img_w = IMG_W_RST;
			img_h = IMG_H_RST;
			errors = 0;
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_MIN_CONF: min_conf = val;
				CFG_IMG_W: img_w = val[IMG_DIM_W-1:0];
				CFG_IMG_H: img_h = val[IMG_DIM_W-1:0];
				default: ;
			endcase
		endfunction

		// Work out the answer to one accepted command
		function void note_item(logic [CODE_W-1:0] cmd, logic [S_TDATA_W-1:0] d);
			answer_t     a;
			bslp_entry_t e;
			int          px, py, bx, by;
			a.status = STAT_OK;
			a.cls = NO_CLASS;
			a.conf = '0;
			case (cmd)
				CMD_CLEAR: fill = 0;
				CMD_ADD: begin
					// confidence floor is tested before table space
					if (d[75:60] < min_conf) begin
						a.status = STAT_LOW_CONF;
					end else if (fill >= BSLP_MAX_DET) begin
						a.status = STAT_FULL;
					end else begin
						e.x = d[12:0];
						e.y = d[25:13];
						e.w = d[37:26];
						e.h = d[49:38];
						e.cls = d[59:50];
						e.conf = d[75:60];
						slot[fill] = e;
						fill++;
					end
				end
				CMD_QUERY: begin
					px = d[87:76];
					py = d[99:88];
					if (px < img_w && py < img_h) begin
						// strictly greater only: earlier entry keeps a tie, zero never wins
						for (int i = 0; i < fill; i++) begin
							bx = $signed(slot[i].x);
							by = $signed(slot[i].y);
							if (slot[i].w != 0 && slot[i].h != 0 &&
							    px >= bx && px < bx + int'(slot[i].w) &&
							    py >= by && py < by + int'(slot[i].h) &&
							    slot[i].conf > a.conf) begin
								a.conf = slot[i].conf;
								a.cls = {1'b0, slot[i].cls};
							end
						end
					end
				end
				default: ;
			endcase
			awaited.push_back(a);
		endfunction

		function void check_answer(logic [CODE_W-1:0] st, logic [M_TDATA_W-1:0] d);
			answer_t a;
			if (awaited.size() == 0) begin
				$error("unexpected result: status %0d class %0d confidence %0d",
				       st, $signed(d[10:0]), d[26:11]);
				errors++;
			end else begin
				a = awaited.pop_front();
				if (st !== a.status) begin
					$error("status: expected %0d, got %0d", a.status, st);
					errors++;
				end
				if (d[10:0] !== a.cls) begin
					$error("pixel_class: expected %0d, got %0d", $signed(a.cls),
					       $signed(d[10:0]));
					errors++;
				end
				if (d[26:11] !== a.conf) begin
					$error("pixel_confidence: expected %0d, got %0d", a.conf, d[26:11]);
					errors++;
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic [CODE_W-1:0]     s_tuser = CMD_CLEAR;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [CODE_W-1:0]     m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_MIN_CONF;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	label_oracle      oracle = new();
	int               idle_pct = 0;
	int               answers_seen = 0;
	int               cycles = 0;
	logic [CONF_W-1:0] cur_min = '0;
	int               cur_w = 640;
	int               cur_h = 480;
	logic [CONF_W-1:0] last_conf = '0;
	rect_t            recent [$];

	box_semantic_label_painter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("box_semantic_label_painter_core verification failed");
			$finish;
		end
	end

	// Monitor: every transaction on the three channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				oracle.set_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				oracle.note_item(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				oracle.check_answer(m_tuser, m_tdata);
				answers_seen++;
			end
		end
	end

	// Result sink: random back-pressure bursts, one long hold-off
	initial begin : result_sink
		int hold;
		bit long_done;
		hold = 0;
		long_done = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!long_done && answers_seen >= LONG_HOLD_AT) begin
				long_done = 1;
				hold = LONG_HOLD;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2) begin
				hold = $urandom_range(1, 14) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Item builders; fields a command ignores carry random bits
	function automatic det_item_t mk_cmd(logic [CODE_W-1:0] cmd);
		det_item_t it;
		it.cmd = cmd;
		it.bx = 13'($urandom);
		it.by = 13'($urandom);
		it.bw = 12'($urandom);
		it.bh = 12'($urandom);
		it.cls = 10'($urandom);
		it.conf = 16'($urandom);
		it.px = 12'($urandom);
		it.py = 12'($urandom);
		return it;
	endfunction

	function automatic det_item_t mk_add(int x, int y, int w, int h, int cls, int conf);
		det_item_t it;
		it = mk_cmd(CMD_ADD);
		it.bx = 13'(x);
		it.by = 13'(y);
		it.bw = 12'(w);
		it.bh = 12'(h);
		it.cls = 10'(cls);
		it.conf = 16'(conf);
		return it;
	endfunction

	function automatic det_item_t mk_query(int px, int py);
		det_item_t it;
		it = mk_cmd(CMD_QUERY);
		it.px = 12'(px);
		it.py = 12'(py);
		return it;
	endfunction

	// Add with geometry mostly near the image, confidence near the floor or tied
	function automatic det_item_t rand_add();
		det_item_t it;
		rect_t     b;
		int        lw, lh;
		it = mk_cmd(CMD_ADD);
		lw = (cur_w == 0) ? 64 : cur_w;
		lh = (cur_h == 0) ? 64 : cur_h;
		if ($urandom_range(0, 9) != 0) begin
			b.x = $urandom_range(0, lw + 16) - 16;
			b.y = $urandom_range(0, lh + 16) - 16;
			if (b.x > 4095) b.x = 4095;
			if (b.y > 4095) b.y = 4095;
			b.w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 48);
			b.h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 48);
			it.bx = 13'(b.x);
			it.by = 13'(b.y);
			it.bw = 12'(b.w);
			it.bh = 12'(b.h);
		end
		case ($urandom_range(0, 7))
			0: it.conf = '0;
			1: it.conf = cur_min;
			2: it.conf = cur_min - 1'b1;
			3: it.conf = last_conf;
			default: ;
		endcase
		last_conf = it.conf;
		b.x = $signed(it.bx);
		b.y = $signed(it.by);
		b.w = it.bw;
		b.h = it.bh;
		if (b.w != 0 && b.h != 0) begin
			recent.push_back(b);
			if (recent.size() > 48) void'(recent.pop_front());
		end
		return it;
	endfunction

	// Query mostly inside or on the rim of a recent box, else anywhere
	function automatic det_item_t rand_query();
		det_item_t it;
		rect_t     b;
		int        r, px, py, lw, lh;
		it = mk_cmd(CMD_QUERY);
		lw = (cur_w == 0) ? 64 : cur_w;
		lh = (cur_h == 0) ? 64 : cur_h;
		r = $urandom_range(0, 9);
		if (r < 6 && recent.size() > 0) begin
			b = recent[$urandom_range(0, recent.size() - 1)];
			px = b.x + $urandom_range(0, b.w - 1);
			py = b.y + $urandom_range(0, b.h - 1);
			case ($urandom_range(0, 4))
				0: begin px = b.x + b.w - 1; py = b.y + b.h - 1; end
				1: px = b.x + b.w;
				2: py = b.y - 1;
				3: begin px = b.x; py = b.y; end
				default: ;
			endcase
			if (px >= 0 && px <= 4095 && py >= 0 && py <= 4095) begin
				it.px = 12'(px);
				it.py = 12'(py);
			end
		end else if (r < 8) begin
			it.px = 12'($urandom_range(0, lw - 1));
			it.py = 12'($urandom_range(0, lh - 1));
		end else if (r == 8) begin
			// right and bottom image border, just inside or just past
			px = lw - $urandom_range(0, 1);
			py = lh - $urandom_range(0, 1);
			it.px = 12'((px > 4095) ? 4095 : px);
			it.py = 12'((py > 4095) ? 4095 : py);
		end
		return it;
	endfunction

	// Offer one item, with an optional gap first, and wait for the transaction
	task automatic send_item(input det_item_t it);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.cmd;
		s_tdata <= {4'b0, it.py, it.px, it.conf, it.cls, it.bh, it.bw, it.by, it.bx};
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop offering and wait until every answer is back
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (oracle.outstanding() != 0);
	endtask

	task automatic write_regs(input logic [CONF_W-1:0] mc, input int w, input int h);
		logic [CFG_IDX_W-1:0]  regs [3];
		logic [CFG_DATA_W-1:0] vals [3];
		regs[0] = CFG_MIN_CONF;
		regs[1] = CFG_IMG_W;
		regs[2] = CFG_IMG_H;
		vals[0] = mc;
		vals[1] = 16'(w);
		vals[2] = 16'(h);
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic reconfigure(input logic [CONF_W-1:0] mc, input int w, input int h);
		settle();
		write_regs(mc, w, h);
		cur_min = mc;
		cur_w = w;
		cur_h = h;
	endtask

	// Random mix: clears, adds, queries, no-ops, and bursts that overfill the table
	task automatic run_mix(input int n);
		int sent, r, burst;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				burst = $urandom_range(30, 38);
				for (int k = 0; k < burst; k++) send_item(rand_add());
				sent += burst;
			end else begin
				if (r < 10) send_item(mk_cmd(CMD_CLEAR));
				else if (r < 45) send_item(rand_add());
				else if (r < 96) send_item(rand_query());
				else send_item(mk_cmd(CMD_NOP));
				sent++;
			end
		end
	endtask

	task automatic run_phase(input int pct, input logic [CONF_W-1:0] mc, input int w,
	                         input int h, input int n);
		reconfigure(mc, w, h);
		idle_pct = pct;
		run_mix(n);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on reset configuration (640 x 480, no floor)
		idle_pct = 15;
		send_item(mk_query(5, 5));
		send_item(mk_cmd(CMD_NOP));
		send_item(mk_add(-4096, -4096, 4095, 4095, 1023, 65535));
		send_item(mk_add(0, 0, 0, 10, 5, 65535));
		send_item(mk_add(10, 20, 5, 5, 7, 1000));
		send_item(mk_add(10, 20, 5, 5, 8, 1000));
		send_item(mk_add(0, 0, 4095, 4095, 9, 0));
		send_item(mk_add(4095, 4095, 4095, 4095, 4, 1));
		send_item(mk_add(630, 470, 20, 20, 2, 500));
		send_item(mk_query(10, 20));
		send_item(mk_query(14, 24));
		send_item(mk_query(15, 20));
		send_item(mk_query(0, 0));
		send_item(mk_query(639, 479));
		send_item(mk_query(640, 479));
		send_item(mk_query(4095, 4095));
		send_item(mk_cmd(CMD_CLEAR));
		send_item(mk_query(10, 20));
		// Highest floor, largest image
		reconfigure(16'hFFFF, 4096, 4096);
		send_item(mk_add(4095, 4095, 1, 1, 1023, 16'hFFFE));
		send_item(mk_add(4095, 4095, 1, 1, 1023, 16'hFFFF));
		send_item(mk_query(4095, 4095));
		send_item(mk_query(0, 4095));

		// Random phases across settings; zero sizes put every pixel outside
		run_phase(20, 16'h0000, 4096, 4096, 116);
		run_phase(35, 16'hFFFF, 1, 1, 116);
		run_phase(10, 16'($urandom_range(0, 16'h3FFF)), $urandom_range(1, 4096),
		          $urandom_range(1, 4096), 116);
		run_phase(0, 16'h0000, 0, 300, 116);
		run_phase(25, 16'h8000, 640, 0, 116);
		run_phase(15, 16'($urandom_range(0, 255)), 4096, 1, 116);
		run_phase(30, 16'($urandom), 1, 4096, 116);
		run_phase(0, 16'h0000, 640, 480, 116);

		settle();
		repeat (40) @(posedge clk);
		if (oracle.errors == 0 && oracle.outstanding() == 0)
			$display("box_semantic_label_painter_core verification clean");
		else
			$display("box_semantic_label_painter_core verification failed");
		$finish;
	end

endmodule

// File: box_semantic_label_painter_core.f
hdl/bslp_pkg.sv
hdl/bslp_dp.sv
hdl/bslp_ctrl.sv
hdl/box_semantic_label_painter_core.sv
tb/tb.sv
